[hdl/sab_pkg.sv]
// Shared types and constants for the suffix array builder.
// Holds the input and result word layouts and the sequencer state codes.
// Depends on nothing else; every other file imports it.
`timescale 1ns / 1ps

package sab_pkg;

  // Fixed field widths of the channel words.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SUFFIX_W = 6;

  // One input word: a text character and its end-of-text mark.
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              is_last;
  } in_word_t;

  // One result word: a suffix start in sorted order and its flags.
  typedef struct packed {
    logic [SUFFIX_W-1:0] suffix_start;
    logic                run_end;
    logic                truncated;
  } out_word_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_KEY_RD,
    ST_KEY_CAP,
    ST_PREV_CAP,
    ST_CMP,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_CAP
  } sab_state_t;

endpackage

[hdl/sab_text_mem.sv]
// Text store: one write port and two registered read ports.
// The two read ports feed the character-by-character suffix compare.
// Depends on sab_pkg for the byte width.
`timescale 1ns / 1ps

module sab_text_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [sab_pkg::BYTE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]          rd_addr_a,
  input  logic [ADDR_W-1:0]          rd_addr_b,
  output logic [sab_pkg::BYTE_W-1:0] rd_data_a,
  output logic [sab_pkg::BYTE_W-1:0] rd_data_b
);
  import sab_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two read ports, each registered.
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

[hdl/sab_order_mem.sv]
// Order store: the suffix start indices, kept in sorted order as the sort runs.
// One write port and one registered read port.
// Depends on sab_pkg only through the shared import convention.
`timescale 1ns / 1ps

module sab_order_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ADDR_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ADDR_W-1:0] rd_data
);
  import sab_pkg::*;

  logic [ADDR_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/suffix_array_builder.sv]
// Suffix array builder: top level with the load, sort and emit sequencer.
// Instantiates sab_text_mem and sab_order_mem; uses types from sab_pkg.
//
// Usage. The input channel (byte_valid, byte_stall, byte_data) takes one text
// character per word; the word with is_last set closes the text. Up to
// MAX_LEN characters are kept, later ones are dropped and every result of
// that run carries truncated. The result channel (result_valid, result_stall,
// result_data) then gives one word per suffix, start indices in ascending
// suffix order, with run_end on the last word.
// Timing. Loading takes one word per cycle. After the last word an insertion
// sort runs over the order store: each key is fetched and then placed, and
// each neighbour it is tested against is fetched and then compared character
// by character, counting the position where a suffix runs out. The worst
// case is a text of one repeated character. Emission reads and then captures
// each result word, and waits before each read while the output register
// still holds a word the receiver has not taken.
// The input channel stalls from the last word until the final result word
// is in the output register; that word may wait there while the next text
// loads. Reset clears the sequencer, the length and the output register; no
// clearing pass over the memories is needed.
`timescale 1ns / 1ps

module suffix_array_builder #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  sab_pkg::in_word_t  byte_data,
  output logic               result_valid,
  input  logic               result_stall,
  output sab_pkg::out_word_t result_data
);
  import sab_pkg::*;

  localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);

  // Sequencer and datapath registers.
  sab_state_t        state;
  sab_state_t        state_next;
  logic [LEN_W-1:0]  len;
  logic              overflow_seen;
  logic [ADDR_W-1:0] i;
  logic [ADDR_W-1:0] j;
  logic [ADDR_W-1:0] k;
  logic [ADDR_W-1:0] key;
  logic [ADDR_W-1:0] prev;
  logic [LEN_W-1:0]  a;
  logic [LEN_W-1:0]  b;
  out_word_t         out_word;
  logic              out_full;

  // Memory port signals.
  logic              txt_we;
  logic [ADDR_W-1:0] txt_waddr;
  logic [ADDR_W-1:0] txt_raddr_a;
  logic [ADDR_W-1:0] txt_raddr_b;
  logic [BYTE_W-1:0] txt_rdata_a;
  logic [BYTE_W-1:0] txt_rdata_b;
  logic              ord_we;
  logic [ADDR_W-1:0] ord_waddr;
  logic [ADDR_W-1:0] ord_wdata;
  logic [ADDR_W-1:0] ord_raddr;
  logic [ADDR_W-1:0] ord_rdata;

  // Decoded conditions.
  logic              in_take;
  logic              out_take;
  logic              store_full;
  logic [LEN_W-1:0]  len_after;
  logic              a_end;
  logic              b_end;
  logic              cmp_done;
  logic              cmp_less;
  logic [LEN_W-1:0]  a_inc;
  logic [LEN_W-1:0]  b_inc;
  logic              last_key;
  logic              last_out;

  sab_text_mem #(
    .DEPTH  (MAX_LEN),
    .ADDR_W (ADDR_W)
  ) u_text (
    .clk       (clk),
    .wr_en     (txt_we),
    .wr_addr   (txt_waddr),
    .wr_data   (byte_data.text_byte),
    .rd_addr_a (txt_raddr_a),
    .rd_addr_b (txt_raddr_b),
    .rd_data_a (txt_rdata_a),
    .rd_data_b (txt_rdata_b)
  );

  sab_order_mem #(
    .DEPTH  (MAX_LEN),
    .ADDR_W (ADDR_W)
  ) u_order (
    .clk     (clk),
    .wr_en   (ord_we),
    .wr_addr (ord_waddr),
    .wr_data (ord_wdata),
    .rd_addr (ord_raddr),
    .rd_data (ord_rdata)
  );

  // Handshake decode and load bookkeeping.
  assign byte_stall = (state != ST_LOAD);
  assign in_take    = byte_valid && !byte_stall;
  assign out_take   = out_full && !result_stall;
  assign store_full = (len == LEN_W'(MAX_LEN));
  assign len_after  = store_full ? len : len + LEN_W'(1);

  // Suffix compare: a suffix that runs out first is a proper prefix and sorts
  // first. Two distinct starts can never both run out at once.
  assign a_end    = (a >= len);
  assign b_end    = (b >= len);
  assign cmp_done = a_end || b_end || (txt_rdata_a != txt_rdata_b);
  assign cmp_less = (a_end || b_end) ? (a_end && !b_end) : (txt_rdata_a < txt_rdata_b);
  assign a_inc    = a + LEN_W'(1);
  assign b_inc    = b + LEN_W'(1);

  assign last_key = (LEN_W'(i) + LEN_W'(1) == len);
  assign last_out = (LEN_W'(k) + LEN_W'(1) == len);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_take && byte_data.is_last) begin
          state_next = (len_after == LEN_W'(1)) ? ST_EMIT_RD : ST_KEY_RD;
        end
      end
      ST_KEY_RD:   state_next = ST_KEY_CAP;
      ST_KEY_CAP:  state_next = ST_PREV_CAP;
      ST_PREV_CAP: state_next = ST_CMP;
      ST_CMP: begin
        if (cmp_done) begin
          if (cmp_less && (j != ADDR_W'(1))) begin
            state_next = ST_PREV_CAP;
          end else begin
            state_next = ST_PLACE;
          end
        end
      end
      ST_PLACE: begin
        state_next = last_key ? ST_EMIT_RD : ST_KEY_RD;
      end
      ST_EMIT_RD: begin
        if (!out_full) begin
          state_next = ST_EMIT_CAP;
        end
      end
      ST_EMIT_CAP: begin
        state_next = last_out ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Memory port drive for each state.
  always_comb begin
    txt_we      = 1'b0;
    txt_waddr   = len[ADDR_W-1:0];
    txt_raddr_a = a[ADDR_W-1:0];
    txt_raddr_b = b[ADDR_W-1:0];
    ord_we      = 1'b0;
    ord_waddr   = j;
    ord_wdata   = key;
    ord_raddr   = i;
    case (state)
      ST_LOAD: begin
        // The identity order is written alongside each stored character.
        txt_we    = in_take && !store_full;
        ord_we    = in_take && !store_full;
        ord_waddr = len[ADDR_W-1:0];
        ord_wdata = len[ADDR_W-1:0];
      end
      ST_KEY_RD: begin
        ord_raddr = i;
      end
      ST_KEY_CAP: begin
        ord_raddr = j - ADDR_W'(1);
      end
      ST_PREV_CAP: begin
        txt_raddr_a = key;
        txt_raddr_b = ord_rdata;
      end
      ST_CMP: begin
        // Fetch the next character pair while the current one is checked.
        txt_raddr_a = a_inc[ADDR_W-1:0];
        txt_raddr_b = b_inc[ADDR_W-1:0];
        // Shift the larger neighbour up and fetch the one below it.
        ord_we      = cmp_done && cmp_less;
        ord_waddr   = j;
        ord_wdata   = prev;
        ord_raddr   = j - ADDR_W'(2);
      end
      ST_PLACE: begin
        ord_we    = 1'b1;
        ord_waddr = j;
        ord_wdata = key;
      end
      ST_EMIT_RD: begin
        ord_raddr = k;
      end
      ST_EMIT_CAP: begin
        ord_raddr = k;
      end
      default: begin
        ord_raddr = i;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      len           <= '0;
      overflow_seen <= 1'b0;
      out_full      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD && in_take) begin
        len <= len_after;
        if (store_full) begin
          overflow_seen <= 1'b1;
        end
      end
      if (state == ST_EMIT_CAP) begin
        out_full <= 1'b1;
        if (last_out) begin
          len           <= '0;
          overflow_seen <= 1'b0;
        end
      end else if (out_take) begin
        out_full <= 1'b0;
      end
    end
  end

  // Sort and emit datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        i <= ADDR_W'(1);
        k <= '0;
      end
      ST_KEY_RD: begin
        j <= i;
      end
      ST_KEY_CAP: begin
        key <= ord_rdata;
      end
      ST_PREV_CAP: begin
        prev <= ord_rdata;
        a    <= LEN_W'(key);
        b    <= LEN_W'(ord_rdata);
      end
      ST_CMP: begin
        if (!cmp_done) begin
          a <= a_inc;
          b <= b_inc;
        end else if (cmp_less) begin
          j <= j - ADDR_W'(1);
        end
      end
      ST_PLACE: begin
        i <= i + ADDR_W'(1);
        k <= '0;
      end
      ST_EMIT_CAP: begin
        out_word.suffix_start <= SUFFIX_W'(ord_rdata);
        out_word.run_end      <= last_out;
        out_word.truncated    <= overflow_seen;
        k                     <= k + ADDR_W'(1);
      end
      default: begin
        k <= k;
      end
    endcase
  end

  assign result_valid = out_full;
  assign result_data  = out_word;

  // The output register is only filled from the emit capture step.
  a_fill_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_full) |-> $past(state == ST_EMIT_CAP))
    else $error("output register filled outside emission");

  // The stored length never passes the store depth.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(MAX_LEN))
    else $error("text length beyond store depth");

  // An insertion never moves past the slot it started from.
  a_insert_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP || state == ST_PLACE) |-> (j <= i))
    else $error("insertion index above key position");

  // Two distinct suffixes are always compared.
  a_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (a != b))
    else $error("suffix compared with itself");

  // A new emission only starts into an empty output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_CAP) |-> !out_full)
    else $error("result word overwritten before it was taken");

endmodule

[verif/sab_checker.sv]
// Checker for the suffix array builder: watches both channels and predicts each result word.
// Keeps its own copy of the loaded text and sorts the suffixes when a text closes.
// Depends on sab_pkg for the word layouts.
`timescale 1ns / 1ps

module sab_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  logic               byte_stall,
  input  sab_pkg::in_word_t  byte_data,
  input  logic               result_valid,
  input  logic               result_stall,
  input  sab_pkg::out_word_t result_data,
  output int                 mismatches,
  output int                 awaited
);

  import sab_pkg::*;

  localparam int unsigned TEXT_DEPTH  = 64;
  localparam int unsigned REPORT_MAX  = 10;

  // Shadow of the block's text store and run flags.
  logic [BYTE_W-1:0]   loaded [0:TEXT_DEPTH-1];
  int unsigned         loaded_len;
  bit                  cut_off;
  out_word_t           sorted_starts [$];

  // True when the suffix starting at a comes before the one starting at b.
  function automatic bit suffix_precedes(input int unsigned a, input int unsigned b);
    int unsigned i;
    int unsigned j;
    i = a;
    j = b;
    while (i < loaded_len && j < loaded_len) begin
      if (loaded[i] != loaded[j]) begin
        return loaded[i] < loaded[j];
      end
      i++;
      j++;
    end
    // The one that ran out first is a proper prefix of the other.
    return (i >= loaded_len) && (j < loaded_len);
  endfunction

  // Insertion sort of the suffix starts, then one expected word per suffix.
  task automatic queue_suffix_order();
    logic [SUFFIX_W-1:0] order [0:TEXT_DEPTH-1];
    logic [SUFFIX_W-1:0] key;
    int unsigned         k;
    int unsigned         pos;
    out_word_t           word;
    for (k = 0; k < loaded_len; k++) begin
      order[k] = k[SUFFIX_W-1:0];
    end
    for (k = 1; k < loaded_len; k++) begin
      key = order[k];
      pos = k;
      while (pos > 0 && suffix_precedes(32'(key), 32'(order[pos-1]))) begin
        order[pos] = order[pos-1];
        pos--;
      end
      order[pos] = key;
    end
    for (k = 0; k < loaded_len; k++) begin
      word.suffix_start = order[k];
      word.run_end      = (k + 1 == loaded_len);
      word.truncated    = cut_off;
      sorted_starts.push_back(word);
    end
  endtask

  // Compare one accepted result word with the oldest expectation.
  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (sorted_starts.size() == 0) begin
      if (mismatches < REPORT_MAX) begin
        $display("%0t: unexpected result word start=%0d run_end=%0b truncated=%0b",
                 $time, got.suffix_start, got.run_end, got.truncated);
      end
      mismatches++;
    end else begin
      want = sorted_starts.pop_front();
      if (got.suffix_start !== want.suffix_start || got.run_end !== want.run_end ||
          got.truncated !== want.truncated) begin
        if (mismatches < REPORT_MAX) begin
          $display("%0t: result mismatch: expected start=%0d run_end=%0b truncated=%0b,",
                   $time, want.suffix_start, want.run_end, want.truncated);
          $display("    got start=%0d run_end=%0b truncated=%0b",
                   got.suffix_start, got.run_end, got.truncated);
        end
        mismatches++;
      end
    end
  endtask

  initial begin
    mismatches = 0;
    awaited    = 0;
    loaded_len = 0;
    cut_off    = 1'b0;
  end

  // Results are checked before a closing word adds new expectations.
  always @(posedge clk) begin
    if (rst) begin
      loaded_len = 0;
      cut_off    = 1'b0;
      sorted_starts.delete();
    end else begin
      if (result_valid && !result_stall) begin
        check_result(result_data);
      end
      if (byte_valid && !byte_stall) begin
        if (loaded_len < TEXT_DEPTH) begin
          loaded[loaded_len] = byte_data.text_byte;
          loaded_len++;
        end else begin
          cut_off = 1'b1;
        end
        if (byte_data.is_last) begin
          queue_suffix_order();
          loaded_len = 0;
          cut_off    = 1'b0;
        end
      end
    end
    awaited = sorted_starts.size();
  end

endmodule

[verif/testbench.sv]
// Top of the suffix array builder testbench: clock, reset, stimulus and verdict.
// Instantiates suffix_array_builder and sab_checker; uses word layouts from sab_pkg.
`timescale 1ns / 1ps

module testbench;

  import sab_pkg::*;

  localparam int unsigned TEXT_MAX    = 64;
  localparam int unsigned CHAR_BUDGET = 280;
  localparam int unsigned QUIET_AFTER = 240;

  typedef enum logic [1:0] {
    ALPHA_FULL,
    ALPHA_PAIR,
    ALPHA_TRIO
  } alphabet_t;

  logic      clk;
  logic      rst;
  logic      byte_valid;
  logic      byte_stall;
  in_word_t  byte_data;
  logic      result_valid;
  logic      result_stall;
  out_word_t result_data;
  int        mismatches;
  int        awaited;

  int unsigned chars_sent;
  int unsigned stall_odds;
  bit          quiet;

  suffix_array_builder #(
    .MAX_LEN(TEXT_MAX)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_data   (byte_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data (result_data)
  );

  sab_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_data   (byte_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data (result_data),
    .mismatches  (mismatches),
    .awaited     (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Receiver side: stall in random bursts, started only while not quiet.
  initial begin
    int unsigned hold;
    hold         = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        result_stall <= 1'b1;
        hold--;
      end else if (!quiet && stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
        result_stall <= 1'b1;
        hold = $urandom_range(0, 4);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Offer one word and hold it until accepted; may first idle for a short burst.
  task automatic push_char(input logic [BYTE_W-1:0] ch, input logic fin,
                           input int unsigned gap_odds);
    if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= '{text_byte: ch, is_last: fin};
    do @(posedge clk); while (byte_stall);
    @(negedge clk);
    chars_sent++;
    if (chars_sent >= QUIET_AFTER) begin
      quiet = 1'b1;
    end
  endtask

  initial begin
    int unsigned       len;
    int unsigned       gap_odds;
    int unsigned       i;
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] ch;
    alphabet_t         alphabet;

    rst        = 1'b1;
    byte_valid = 1'b0;
    byte_data  = '0;
    chars_sent = 0;
    stall_odds = 0;
    quiet      = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Single character text at the top of the byte range.
    push_char(8'hFF, 1'b1, 0);
    // A suffix that is a proper prefix of a longer one, with both byte extremes.
    push_char(8'h00, 1'b0, 0);
    push_char(8'hFF, 1'b0, 0);
    push_char(8'h00, 1'b1, 0);
    // All characters equal: shorter suffixes come first.
    stall_odds = 4;
    repeat (3) push_char(8'h61, 1'b0, 0);
    push_char(8'h61, 1'b1, 0);
    // Bytes either side of the sign boundary must compare unsigned.
    push_char(8'h80, 1'b0, 2);
    push_char(8'h7F, 1'b0, 2);
    push_char(8'h80, 1'b0, 2);
    push_char(8'h7F, 1'b0, 2);
    push_char(8'h01, 1'b1, 2);
    // A classic text with repeated overlapping substrings.
    push_char(8'h62, 1'b0, 0);
    push_char(8'h61, 1'b0, 0);
    push_char(8'h6E, 1'b0, 0);
    push_char(8'h61, 1'b0, 0);
    push_char(8'h6E, 1'b0, 0);
    push_char(8'h61, 1'b1, 0);

    // A full store of one repeated character: the slowest sort.
    stall_odds = 3;
    for (i = 0; i < TEXT_MAX; i++) begin
      push_char(8'h55, i == TEXT_MAX - 1, 4);
    end

    // One word too many: the closing word is dropped and the run is truncated.
    base = BYTE_W'($urandom_range(0, 254));
    for (i = 0; i <= TEXT_MAX; i++) begin
      push_char(BYTE_W'(base + $urandom_range(0, 1)), i == TEXT_MAX, 3);
    end

    // Random short texts over full and narrow alphabets.
    while (chars_sent < CHAR_BUDGET) begin
      len        = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      alphabet   = alphabet_t'($urandom_range(0, 2));
      base       = BYTE_W'($urandom_range(0, 253));
      gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : 3;
      stall_odds = ($urandom_range(0, 3) == 0) ? 0 : 5;
      for (i = 0; i < len; i++) begin
        case (alphabet)
          ALPHA_PAIR: begin
            ch = BYTE_W'(base + $urandom_range(0, 1));
          end
          ALPHA_TRIO: begin
            ch = BYTE_W'(base + $urandom_range(0, 2));
          end
          default: begin
            ch = BYTE_W'($urandom_range(0, 255));
          end
        endcase
        push_char(ch, i == len - 1, gap_odds);
      end
    end
    byte_valid <= 1'b0;

    // Drain the outstanding results, then give the block a little longer.
    wait (awaited == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
